FILE: src/stream_segment_reassembly_assert.svh
// Assertion helpers for the reassembly block.
`ifndef STREAM_SEGMENT_REASSEMBLY_ASSERT_SVH
`define STREAM_SEGMENT_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ssr_pkg.sv
`default_nettype none
package ssr_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int MAX_READ     = 64;
    localparam int CNT_W        = 7;
    localparam int OFF_W        = 32;

    localparam logic [1:0] KIND_SEG  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    typedef struct packed {
        logic clr;       // clear one flag entry at the sweep pointer
        logic seg;       // store a segment byte
        logic fin;       // mark end of stream
        logic rd_start;  // load read count, reset run
        logic take;      // consume the byte at next offset
        logic out_pend;  // move pending byte to output register
        logic out_stat;  // load a status-only word into the output register
        logic last;      // last flag for out_pend
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic fresh;       // read data matches the current next offset
        logic flag_valid;
        logic flag_start;
        logic first;       // no byte taken yet in this run
        logic count_hit;   // a take now reaches the read count
        logic pend_valid;
        logic out_room;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/ssr_datapath.sv
`default_nettype none
module ssr_datapath import ssr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [OFF_W-1:0]  i_offset,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_seg_start,
    input  wire logic [CNT_W-1:0]  i_count,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic [1:0]             o_out_status,
    output logic                   o_out_last
);

    logic [7:0]        r_store [WINDOW_BYTES];
    logic [1:0]        r_flags [WINDOW_BYTES];   // {start, valid}

    logic [OFF_W-1:0]  r_next_off;
    logic [OFF_W-1:0]  n_next_off;
    logic              r_fin;
    logic [WIN_AW-1:0] r_clr_addr;
    logic              r_fresh;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic              r_pend_valid;
    logic [7:0]        r_pend_byte;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [1:0]        r_out_status;
    logic              r_out_last;
    logic [1:0]        r_rd_flags;
    logic [7:0]        r_rd_byte;

    logic [OFF_W-1:0]  win_dist;
    logic              in_win;
    logic              seg_we;
    logic [WIN_AW-1:0] rd_addr;
    logic              flags_we;
    logic [WIN_AW-1:0] flags_wa;
    logic [1:0]        flags_wd;
    logic [CNT_W-1:0]  cnt_clamped;
    logic              out_room;

    assign win_dist   = i_offset - r_next_off;
    assign in_win     = (win_dist[OFF_W-1:WIN_AW] == '0);
    assign seg_we     = i_cmd.seg && in_win;
    assign n_next_off = i_cmd.take ? r_next_off + 1'b1 : r_next_off;
    assign rd_addr    = n_next_off[WIN_AW-1:0];
    assign out_room   = !r_out_valid || i_out_ready;

    always_comb begin
        flags_we = 1'b1;
        flags_wa = r_next_off[WIN_AW-1:0];
        flags_wd = 2'b00;
        priority if (i_cmd.clr) begin
            flags_wa = r_clr_addr;
        end else if (seg_we) begin
            flags_wa = i_offset[WIN_AW-1:0];
            flags_wd = {i_seg_start, 1'b1};
        end else if (i_cmd.take) begin
            flags_wa = r_next_off[WIN_AW-1:0];
        end else begin
            flags_we = 1'b0;
        end
    end

    always_comb begin
        priority if (i_count == '0) begin
            cnt_clamped = CNT_W'(1);
        end else if (i_count > CNT_W'(MAX_READ)) begin
            cnt_clamped = CNT_W'(MAX_READ);
        end else begin
            cnt_clamped = i_count;
        end
    end

    // Both memories are read at the next offset every cycle.
    always_ff @(posedge i_clk) begin
        if (flags_we) begin
            r_flags[flags_wa] <= flags_wd;
        end
        r_rd_flags <= r_flags[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_store[i_offset[WIN_AW-1:0]] <= i_byte;
        end
        r_rd_byte <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_off   <= '0;
            r_fin        <= 1'b0;
            r_clr_addr   <= '0;
            r_fresh      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_next_off <= n_next_off;
            // a write can hit the slot being read, so the registered read data is stale
            r_fresh    <= !(i_cmd.clr || i_cmd.seg);
            if (i_cmd.fin) begin
                r_fin <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.rd_start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.out_pend) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.out_pend || i_cmd.out_stat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_count <= cnt_clamped;
            r_n     <= '0;
        end else if (i_cmd.take) begin
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.take) begin
            r_pend_byte <= r_rd_byte;
        end
        if (i_cmd.out_pend) begin
            r_out_byte   <= r_pend_byte;
            r_out_status <= ST_DATA;
            r_out_last   <= i_cmd.last;
        end else if (i_cmd.out_stat) begin
            r_out_byte   <= 8'd0;
            r_out_status <= r_fin ? ST_END : ST_WAIT;
            r_out_last   <= 1'b1;
        end
    end

    assign o_sts.clr_done   = (r_clr_addr == '1);
    assign o_sts.fresh      = r_fresh;
    assign o_sts.flag_valid = r_rd_flags[0];
    assign o_sts.flag_start = r_rd_flags[1];
    assign o_sts.first      = (r_n == '0);
    assign o_sts.count_hit  = ((r_n + 1'b1) == r_count);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_room   = out_room;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule
`default_nettype wire

FILE: src/ssr_ctrl.sv
`default_nettype none
`include "stream_segment_reassembly_assert.svh"
module ssr_ctrl import ssr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_kind,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_SEG:  o_cmd.seg = 1'b1;
                        KIND_READ: begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_READ;
                        end
                        KIND_FIN:  o_cmd.fin = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (i_sts.fresh && i_sts.out_room) begin
                    if (i_sts.flag_valid && (i_sts.first || !i_sts.flag_start)) begin
                        // previous byte is known not to be last once this one is taken
                        o_cmd.take     = 1'b1;
                        o_cmd.out_pend = i_sts.pend_valid;
                        if (i_sts.count_hit) begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        if (i_sts.first) begin
                            o_cmd.out_stat = 1'b1;
                        end else begin
                            o_cmd.out_pend = 1'b1;
                            o_cmd.last     = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_room) begin
                    o_cmd.out_pend = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `SSR_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_cmd.out_pend || o_cmd.out_stat, i_sts.out_room, "word pushed into full output register")
    `SSR_ASSERT_IMP(a_take_valid, i_clk, i_rst_n, o_cmd.take, i_sts.fresh && i_sts.flag_valid, "byte taken from stale or empty slot")
    `SSR_ASSERT_IMP(a_stat_alone, i_clk, i_rst_n, o_cmd.out_stat, !o_cmd.out_pend && !i_sts.pend_valid, "status word with data pending")
    `SSR_ASSERT_NXT(a_flush_done, i_clk, i_rst_n, (r_state == S_FLUSH) && i_sts.out_room, r_state == S_IDLE, "flush did not return to idle")

endmodule
`default_nettype wire

FILE: src/stream_segment_reassembly.sv
// Segment byte, finish or unknown kind: no output word; accepted back to back.
// Read request of n bytes: accept, then one byte per cycle from the registered window read
// while the output has room, then the last word is pushed; an empty read gives a status word.
// Output register: a word appears in the cycle after it is formed; downstream stalls hold the run.
// Reset: synchronous, active low; afterwards a sweep clears the valid and start flags
// of all 4096 window entries, during which s_axis_tready stays low.
`default_nettype none
module stream_segment_reassembly import ssr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // stream_offset[31:0], byte_value[39:32],
                                            // segment_start[40], read_count[47:41]
    input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // data_byte[7:0]
    output logic [1:0]       m_axis_tuser,  // status[1:0]
    output logic             m_axis_tlast   // last_of_run
);

    t_cmd cmd;
    t_sts sts;

    ssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ssr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_offset     (s_axis_tdata[31:0]),
        .i_byte       (s_axis_tdata[39:32]),
        .i_seg_start  (s_axis_tdata[40]),
        .i_count      (s_axis_tdata[47:41]),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule
`default_nettype wire
